// ===== design/reu_pkg.sv =====
// Shared types and constants for the root election update block.
`default_nettype none

package reu_pkg;

  localparam int unsigned IdW      = 16;
  localparam int unsigned CostW    = 16;
  localparam int unsigned AgeW     = 32;
  localparam int unsigned SelW     = 2;
  localparam int unsigned NumLinks = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [AgeW-1:0]  AgeInfinite = '1;
  localparam logic [CostW-1:0] CostMax     = '1;
  localparam logic [AgeW-1:0]  MaxAgeReset = AgeW'(1000);
  localparam logic [CostW-1:0] LinkReset   = CostW'(1);

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_NODE_ID = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_AGE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LINK_A  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LINK_B  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LINK_C  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LINK_D  = 3'd5;

  // Item kinds
  localparam logic ACT_MSG  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic            action;
    logic [SelW-1:0] from_neighbor;
    logic [IdW-1:0]  reported_root;
    logic [CostW-1:0] reported_cost;
    logic [IdW-1:0]  sender_id;
    logic [AgeW-1:0] reported_age;
  } msg_t;

  typedef struct packed {
    logic [IdW-1:0]   cur_root;
    logic [CostW-1:0] cur_cost;
    logic             parent_valid;
    logic [SelW-1:0]  parent_sel;
    logic [AgeW-1:0]  root_age;
  } view_t;

  typedef struct packed {
    logic             changed;
    logic             crash_seen;
    logic [IdW-1:0]   root_id;
    logic [CostW-1:0] path_cost;
    logic             has_parent;
    logic [SelW-1:0]  parent_index;
    logic [AgeW-1:0]  advertised_age;
  } res_t;

  typedef struct packed {
    logic            drop;
    logic            crash;
    logic [SelW-1:0] crash_sel;
    view_t           view;
    res_t            res;
  } upd_t;

endpackage

`default_nettype wire

// ===== design/reu_msg_if.sv =====
// Input message channel: valid/ready with the message fields.
`default_nettype none

interface reu_msg_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  from_neighbor;
  logic [15:0] reported_root;
  logic [15:0] reported_cost;
  logic [15:0] sender_id;
  logic [31:0] reported_age;

  modport source (
    output valid, action, from_neighbor, reported_root, reported_cost, sender_id,
           reported_age,
    input  ready
  );
  modport sink (
    input  valid, action, from_neighbor, reported_root, reported_cost, sender_id,
           reported_age,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/reu_res_if.sv =====
// Result channel: valid/ready with the node's view after each message.
`default_nettype none

interface reu_res_if;
  logic        valid;
  logic        ready;
  logic        changed;
  logic        crash_seen;
  logic [15:0] root_id;
  logic [15:0] path_cost;
  logic        has_parent;
  logic [1:0]  parent_index;
  logic [31:0] advertised_age;

  modport source (
    output valid, changed, crash_seen, root_id, path_cost, has_parent, parent_index,
           advertised_age,
    input  ready
  );
  modport sink (
    input  valid, changed, crash_seen, root_id, path_cost, has_parent, parent_index,
           advertised_age,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/reu_decide.sv =====
// Single-pass judgment of one message: adoption, crash check and advertised age.
`default_nettype none

module reu_decide #(
  parameter int unsigned NEIGHBORS = 4
) (
  input  reu_pkg::msg_t                   msg_i,
  input  reu_pkg::view_t                  view_i,
  input  logic [reu_pkg::IdW-1:0]         node_id_i,
  input  logic [reu_pkg::AgeW-1:0]        max_age_i,
  input  logic [reu_pkg::CostW-1:0]       link_cost_i [reu_pkg::NumLinks],
  input  logic                            peer_known_i [NEIGHBORS],
  input  logic [reu_pkg::IdW-1:0]         peer_id_i [NEIGHBORS],
  input  logic                            heard_valid_i [NEIGHBORS],
  input  logic [reu_pkg::AgeW-1:0]        last_heard_i [NEIGHBORS],
  input  logic [reu_pkg::AgeW-1:0]        time_now_i,
  output reu_pkg::upd_t                   upd_o
);

  localparam logic [reu_pkg::SelW:0] NbLimit = (reu_pkg::SelW+1)'(NEIGHBORS);

  logic [reu_pkg::SelW-1:0]  n;
  logic [reu_pkg::SelW-1:0]  p_old;
  logic [reu_pkg::SelW-1:0]  p_new;
  logic [reu_pkg::CostW:0]   sum_wide;
  logic [reu_pkg::CostW-1:0] sum;
  logic [reu_pkg::IdW-1:0]   pid_n;
  logic [reu_pkg::IdW-1:0]   pid_p;
  logic                      hv_p;
  logic [reu_pkg::AgeW-1:0]  lh_p;
  logic [reu_pkg::AgeW-1:0]  elapsed;
  logic [reu_pkg::AgeW-1:0]  el_final;
  logic [reu_pkg::AgeW-1:0]  age_new;
  logic                      adopt;
  logic                      pv_new;
  logic                      crash;
  reu_pkg::view_t            view_f;

  assign n     = msg_i.from_neighbor;
  assign p_old = view_i.parent_sel;

  // Saturating path cost through the sending link
  assign sum_wide = {1'b0, msg_i.reported_cost} + {1'b0, link_cost_i[n]};
  assign sum      = sum_wide[reu_pkg::CostW] ? reu_pkg::CostMax
                                             : sum_wide[reu_pkg::CostW-1:0];

  // Peer ids as seen after first-contact recording
  always_comb begin
    pid_n = msg_i.sender_id;
    pid_p = msg_i.sender_id;
    for (int i = 0; i < NEIGHBORS; i++) begin
      if (n == reu_pkg::SelW'(i) && peer_known_i[i]) begin
        pid_n = peer_id_i[i];
      end
      if (p_old == reu_pkg::SelW'(i) && (n != p_old || peer_known_i[i])) begin
        pid_p = peer_id_i[i];
      end
    end
  end

  always_comb begin
    adopt = 1'b0;
    if (msg_i.reported_root < view_i.cur_root) begin
      adopt = 1'b1;
    end else if (msg_i.reported_root == view_i.cur_root) begin
      if (sum < view_i.cur_cost) begin
        adopt = 1'b1;
      end else if (sum == view_i.cur_cost && view_i.parent_valid && pid_n < pid_p) begin
        adopt = 1'b1;
      end
    end
  end

  assign p_new   = adopt ? n : p_old;
  assign pv_new  = adopt | view_i.parent_valid;
  assign age_new = adopt ? msg_i.reported_age : view_i.root_age;

  // Last-heard entry of the parent chosen after adoption
  always_comb begin
    hv_p = 1'b0;
    lh_p = '0;
    for (int i = 0; i < NEIGHBORS; i++) begin
      if (p_new == reu_pkg::SelW'(i)) begin
        hv_p = heard_valid_i[i];
        lh_p = last_heard_i[i];
      end
    end
  end

  assign elapsed = time_now_i - lh_p;

  assign crash = pv_new && ((hv_p && elapsed > max_age_i) ||
                            (n == p_new && msg_i.reported_age > age_new));

  always_comb begin
    if (crash) begin
      view_f.cur_root     = node_id_i;
      view_f.cur_cost     = '0;
      view_f.parent_valid = 1'b0;
      view_f.parent_sel   = '0;
      view_f.root_age     = reu_pkg::AgeInfinite;
    end else begin
      view_f.cur_root     = adopt ? msg_i.reported_root : view_i.cur_root;
      view_f.cur_cost     = adopt ? sum : view_i.cur_cost;
      view_f.parent_valid = pv_new;
      view_f.parent_sel   = p_new;
      view_f.root_age     = age_new;
    end
  end

  // The sender was just heard, so a parent equal to it has no silence yet
  assign el_final = (!view_f.parent_valid || n == p_new || !hv_p) ? '0 : elapsed;

  always_comb begin
    upd_o.drop      = ({1'b0, n} >= NbLimit);
    upd_o.crash     = crash;
    upd_o.crash_sel = p_new;
    upd_o.view      = view_f;
    upd_o.res.changed      = adopt | crash;
    upd_o.res.crash_seen   = crash;
    upd_o.res.root_id      = view_f.cur_root;
    upd_o.res.path_cost    = view_f.cur_cost;
    upd_o.res.has_parent   = view_f.parent_valid;
    upd_o.res.parent_index = view_f.parent_valid ? view_f.parent_sel : '0;
    if (view_f.root_age == reu_pkg::AgeInfinite) begin
      upd_o.res.advertised_age = max_age_i;
    end else if (el_final >= view_f.root_age) begin
      upd_o.res.advertised_age = '0;
    end else begin
      upd_o.res.advertised_age = view_f.root_age - el_final;
    end
  end

endmodule

`default_nettype wire

// ===== design/root_election_update_core.sv =====
// Root election update for one node: message and tick items in, node view out.
//
// Usage:
//   msg_i carries items: action 0 is a message from neighbor from_neighbor,
//   action 1 is a time tick. Each accepted message from a neighbor below
//   NEIGHBORS gives one result on res_o; ticks and messages from higher
//   neighbor indexes give none.
//   Registers (node_id, max_age, four link costs) are written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle.
// Timing:
//   An accepted item lands in an input register; it is then judged against the
//   held view and, for a message, the result register loads, raising res_o.valid.
//   One item per cycle is sustained while results are taken: the judgment is a
//   single pass of one 17-bit add, two 32-bit subtracts and a few compares between
//   the input register and the result register.
// Stalls and reset:
//   While res_o.ready is low with a result waiting, a message in the input
//   register holds and msg_i.ready drops; a tick or a dropped message passes.
//   Reset clears both registers, the view (own root, cost 0, no parent,
//   infinite age), the peer and last-heard valid flags, and the tick count.
`default_nettype none

module root_election_update_core #(
  parameter int unsigned NEIGHBORS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [reu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [reu_pkg::CfgDataW-1:0]   cfg_wdata_i,
  reu_msg_if.sink                        msg_i,
  reu_res_if.source                      res_o
);

  logic                           in_vld_q;
  reu_pkg::msg_t                  in_q;
  logic                           out_vld_q;
  reu_pkg::res_t                  out_q;
  reu_pkg::view_t                 view_q;
  logic [reu_pkg::IdW-1:0]        node_id_q;
  logic [reu_pkg::AgeW-1:0]       max_age_q;
  logic [reu_pkg::CostW-1:0]      link_cost_q [reu_pkg::NumLinks];
  logic                           peer_known_q [NEIGHBORS];
  logic [reu_pkg::IdW-1:0]        peer_id_q [NEIGHBORS];
  logic                           heard_valid_q [NEIGHBORS];
  logic [reu_pkg::AgeW-1:0]       last_heard_q [NEIGHBORS];
  logic [reu_pkg::AgeW-1:0]       time_now_q;
  reu_pkg::upd_t                  upd;
  logic                           is_msg;
  logic                           out_free;
  logic                           process;
  logic                           emit;
  logic                           in_take;

  reu_decide #(
    .NEIGHBORS (NEIGHBORS)
  ) u_decide (
    .msg_i         (in_q),
    .view_i        (view_q),
    .node_id_i     (node_id_q),
    .max_age_i     (max_age_q),
    .link_cost_i   (link_cost_q),
    .peer_known_i  (peer_known_q),
    .peer_id_i     (peer_id_q),
    .heard_valid_i (heard_valid_q),
    .last_heard_i  (last_heard_q),
    .time_now_i    (time_now_q),
    .upd_o         (upd)
  );

  assign is_msg   = (in_q.action == reu_pkg::ACT_MSG);
  assign out_free = !out_vld_q || res_o.ready;
  // Ticks and dropped messages need no room in the result register
  assign process  = in_vld_q && (out_free || !is_msg || upd.drop);
  assign emit     = process && is_msg && !upd.drop;
  assign in_take  = msg_i.valid && msg_i.ready;

  assign msg_i.ready = !in_vld_q || process;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (msg_i.ready) begin
      in_vld_q <= msg_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.action        <= msg_i.action;
      in_q.from_neighbor <= msg_i.from_neighbor;
      in_q.reported_root <= msg_i.reported_root;
      in_q.reported_cost <= msg_i.reported_cost;
      in_q.sender_id     <= msg_i.sender_id;
      in_q.reported_age  <= msg_i.reported_age;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= upd.res;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.changed        = out_q.changed;
  assign res_o.crash_seen     = out_q.crash_seen;
  assign res_o.root_id        = out_q.root_id;
  assign res_o.path_cost      = out_q.path_cost;
  assign res_o.has_parent     = out_q.has_parent;
  assign res_o.parent_index   = out_q.parent_index;
  assign res_o.advertised_age = out_q.advertised_age;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= '0;
      max_age_q <= reu_pkg::MaxAgeReset;
      for (int i = 0; i < reu_pkg::NumLinks; i++) begin
        link_cost_q[i] <= reu_pkg::LinkReset;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        reu_pkg::CFG_NODE_ID: node_id_q      <= cfg_wdata_i[reu_pkg::IdW-1:0];
        reu_pkg::CFG_MAX_AGE: max_age_q      <= cfg_wdata_i[reu_pkg::AgeW-1:0];
        reu_pkg::CFG_LINK_A:  link_cost_q[0] <= cfg_wdata_i[reu_pkg::CostW-1:0];
        reu_pkg::CFG_LINK_B:  link_cost_q[1] <= cfg_wdata_i[reu_pkg::CostW-1:0];
        reu_pkg::CFG_LINK_C:  link_cost_q[2] <= cfg_wdata_i[reu_pkg::CostW-1:0];
        reu_pkg::CFG_LINK_D:  link_cost_q[3] <= cfg_wdata_i[reu_pkg::CostW-1:0];
        default: ;
      endcase
    end
  end

  // Node view; a new node id also moves the root when there is no parent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q.cur_root     <= '0;
      view_q.cur_cost     <= '0;
      view_q.parent_valid <= 1'b0;
      view_q.parent_sel   <= '0;
      view_q.root_age     <= reu_pkg::AgeInfinite;
    end else if (emit) begin
      view_q <= upd.view;
    end else if (cfg_we_i && cfg_idx_i == reu_pkg::CFG_NODE_ID && !view_q.parent_valid) begin
      view_q.cur_root <= cfg_wdata_i[reu_pkg::IdW-1:0];
    end
  end

  // Tick count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q <= '0;
    end else if (process && !is_msg) begin
      time_now_q <= time_now_q + reu_pkg::AgeW'(1);
    end
  end

  // Peer flags; the sender's heard flag wins over a crash clear of the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NEIGHBORS; i++) begin
        peer_known_q[i]  <= 1'b0;
        heard_valid_q[i] <= 1'b0;
      end
    end else if (emit) begin
      for (int i = 0; i < NEIGHBORS; i++) begin
        if (in_q.from_neighbor == reu_pkg::SelW'(i)) begin
          peer_known_q[i]  <= 1'b1;
          heard_valid_q[i] <= 1'b1;
        end else if (upd.crash && upd.crash_sel == reu_pkg::SelW'(i)) begin
          heard_valid_q[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      for (int i = 0; i < NEIGHBORS; i++) begin
        if (in_q.from_neighbor == reu_pkg::SelW'(i)) begin
          last_heard_q[i] <= time_now_q;
          if (!peer_known_q[i]) begin
            peer_id_q[i] <= in_q.sender_id;
          end
        end
      end
    end
  end

  // Without a parent the node is its own root at cost zero with infinite age
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !view_q.parent_valid |-> (view_q.cur_cost == '0 &&
                              view_q.root_age == reu_pkg::AgeInfinite))
    else $error("orphan view carries cost or age");

  // A chosen parent is always a real neighbor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    view_q.parent_valid |-> ({1'b0, view_q.parent_sel} < (reu_pkg::SelW+1)'(NEIGHBORS)))
    else $error("parent index beyond neighbor count");

  // A new result comes only from a judged message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (!$past(out_vld_q) || $past(res_o.ready))) |->
      $past(emit))
    else $error("result appeared without a judged message");

  // A crash always leaves the node without a parent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && upd.crash) |=> !view_q.parent_valid)
    else $error("crash left a parent in place");

  // The tick count moves only on a processed tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(process && !is_msg) |-> $stable(time_now_q))
    else $error("tick count moved without a tick");

endmodule

`default_nettype wire

// ===== bench/root_election_update_core_test.sv =====
// Self-checking testbench for root_election_update_core against a view predictor.
`timescale 1ns / 100ps

module root_election_update_core_test;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned SettleCycles = 4;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [reu_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [reu_pkg::CfgDataW-1:0] cfg_wdata_i;

  reu_msg_if msg_ch ();
  reu_res_if res_ch ();

  root_election_update_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .msg_i       (msg_ch),
    .res_o       (res_ch)
  );

  // Register copies, at their reset values
  logic [reu_pkg::IdW-1:0] own_id = '0;
  logic [reu_pkg::AgeW-1:0] age_limit = reu_pkg::MaxAgeReset;
  logic [reu_pkg::CostW-1:0] link_cost [reu_pkg::NumLinks] =
    '{reu_pkg::LinkReset, reu_pkg::LinkReset, reu_pkg::LinkReset, reu_pkg::LinkReset};

  // Node view and neighbor tables, at their reset values
  logic [reu_pkg::IdW-1:0] v_root = '0;
  logic [reu_pkg::CostW-1:0] v_cost = '0;
  logic v_par_ok = 1'b0;
  logic [reu_pkg::SelW-1:0] v_par = '0;
  logic [reu_pkg::AgeW-1:0] v_age = reu_pkg::AgeInfinite;
  logic peer_known [reu_pkg::NumLinks] = '{1'b0, 1'b0, 1'b0, 1'b0};
  logic [reu_pkg::IdW-1:0] peer_idn [reu_pkg::NumLinks] = '{16'd0, 16'd0, 16'd0, 16'd0};
  logic heard_ok [reu_pkg::NumLinks] = '{1'b0, 1'b0, 1'b0, 1'b0};
  logic [reu_pkg::AgeW-1:0] heard_at [reu_pkg::NumLinks] = '{32'd0, 32'd0, 32'd0, 32'd0};
  logic [reu_pkg::AgeW-1:0] tick_count = '0;

  reu_pkg::msg_t items_pending[$];
  reu_pkg::res_t views_due[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit hold_request = 1'b0;
  bit offering = 1'b0;

  always #5 clk_i = ~clk_i;

  // Apply one accepted item to the predicted view; a message yields one expected result.
  task automatic advance_view(input reu_pkg::msg_t m);
    logic [reu_pkg::SelW-1:0] n;
    logic [reu_pkg::SelW-1:0] p;
    logic [reu_pkg::CostW:0] total;
    logic [reu_pkg::CostW-1:0] offer_cost;
    logic [reu_pkg::AgeW-1:0] elapsed;
    logic adopt;
    logic crash;
    reu_pkg::res_t r;
    if (m.action == reu_pkg::ACT_TICK) begin
      tick_count = tick_count + 1'b1;
    end else begin
      n = m.from_neighbor;
      if (!peer_known[n]) begin
        peer_known[n] = 1'b1;
        peer_idn[n] = m.sender_id;
      end
      total = {1'b0, m.reported_cost} + {1'b0, link_cost[n]};
      offer_cost = total[reu_pkg::CostW] ? reu_pkg::CostMax : total[reu_pkg::CostW-1:0];
      p = v_par;
      adopt = (m.reported_root < v_root) ||
              (m.reported_root == v_root && (offer_cost < v_cost ||
               (offer_cost == v_cost && v_par_ok && peer_idn[n] < peer_idn[p])));
      if (adopt) begin
        v_root = m.reported_root;
        v_cost = offer_cost;
        v_par = n;
        v_par_ok = 1'b1;
        v_age = m.reported_age;
      end
      // Parent silent too long, or parent reports an older root: fall back to own root
      crash = 1'b0;
      p = v_par;
      if (v_par_ok) begin
        if (heard_ok[p] && (tick_count - heard_at[p]) > age_limit) crash = 1'b1;
        if (n == p && m.reported_age > v_age) crash = 1'b1;
      end
      if (crash) begin
        heard_ok[p] = 1'b0;
        v_cost = '0;
        v_root = own_id;
        v_age = reu_pkg::AgeInfinite;
        v_par_ok = 1'b0;
        v_par = '0;
      end
      heard_at[n] = tick_count;
      heard_ok[n] = 1'b1;
      p = v_par;
      if (v_age == reu_pkg::AgeInfinite) begin
        r.advertised_age = age_limit;
      end else begin
        elapsed = (v_par_ok && heard_ok[p]) ? tick_count - heard_at[p] : '0;
        r.advertised_age = (elapsed >= v_age) ? '0 : v_age - elapsed;
      end
      r.changed = adopt || crash;
      r.crash_seen = crash;
      r.root_id = v_root;
      r.path_cost = v_cost;
      r.has_parent = v_par_ok;
      r.parent_index = v_par_ok ? v_par : '0;
      views_due.push_back(r);
    end
  endtask

  task automatic write_reg(input logic [reu_pkg::CfgIdxW-1:0] idx,
                           input logic [reu_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      reu_pkg::CFG_NODE_ID: begin
        own_id = data[reu_pkg::IdW-1:0];
        if (!v_par_ok) v_root = own_id;
      end
      reu_pkg::CFG_MAX_AGE: age_limit = data;
      reu_pkg::CFG_LINK_A: link_cost[0] = data[reu_pkg::CostW-1:0];
      reu_pkg::CFG_LINK_B: link_cost[1] = data[reu_pkg::CostW-1:0];
      reu_pkg::CFG_LINK_C: link_cost[2] = data[reu_pkg::CostW-1:0];
      reu_pkg::CFG_LINK_D: link_cost[3] = data[reu_pkg::CostW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_links(input logic [reu_pkg::CostW-1:0] a,
                           input logic [reu_pkg::CostW-1:0] b,
                           input logic [reu_pkg::CostW-1:0] c,
                           input logic [reu_pkg::CostW-1:0] d);
    write_reg(reu_pkg::CFG_LINK_A, reu_pkg::CfgDataW'(a));
    write_reg(reu_pkg::CFG_LINK_B, reu_pkg::CfgDataW'(b));
    write_reg(reu_pkg::CFG_LINK_C, reu_pkg::CfgDataW'(c));
    write_reg(reu_pkg::CFG_LINK_D, reu_pkg::CfgDataW'(d));
  endtask

  task automatic push_msg(input logic [reu_pkg::SelW-1:0] n,
                          input logic [reu_pkg::IdW-1:0] root,
                          input logic [reu_pkg::CostW-1:0] cost,
                          input logic [reu_pkg::IdW-1:0] sid,
                          input logic [reu_pkg::AgeW-1:0] age);
    reu_pkg::msg_t m;
    m.action = reu_pkg::ACT_MSG;
    m.from_neighbor = n;
    m.reported_root = root;
    m.reported_cost = cost;
    m.sender_id = sid;
    m.reported_age = age;
    items_pending.push_back(m);
  endtask

  task automatic push_ticks(input int unsigned count);
    reu_pkg::msg_t m;
    m = '0;
    m.action = reu_pkg::ACT_TICK;
    m.from_neighbor = reu_pkg::SelW'($urandom_range(3));
    m.reported_root = reu_pkg::IdW'($urandom);
    m.reported_cost = reu_pkg::CostW'($urandom);
    m.sender_id = reu_pkg::IdW'($urandom);
    m.reported_age = $urandom;
    repeat (count) items_pending.push_back(m);
  endtask

  // Mostly offers that land near the current root and cost, plus tick bursts to age the parent.
  task automatic queue_traffic(input int unsigned count);
    int unsigned made;
    int unsigned burst;
    int unsigned pick;
    logic [reu_pkg::IdW-1:0] root;
    logic [reu_pkg::CostW-1:0] cost;
    logic [reu_pkg::IdW-1:0] sid;
    logic [reu_pkg::AgeW-1:0] age;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 25) begin
        burst = $urandom_range(1, 8);
        push_ticks(burst);
        made += burst;
      end else begin
        pick = $urandom_range(99);
        if (pick < 40) root = reu_pkg::IdW'($urandom_range(5));
        else if (pick < 70) root = own_id - reu_pkg::IdW'($urandom_range(3));
        else if (pick < 85) root = own_id;
        else root = reu_pkg::IdW'($urandom);
        pick = $urandom_range(99);
        if (pick < 80) cost = reu_pkg::CostW'($urandom_range(6));
        else if (pick < 90) cost = reu_pkg::CostMax - reu_pkg::CostW'($urandom_range(3));
        else cost = reu_pkg::CostW'($urandom);
        sid = ($urandom_range(99) < 70) ? reu_pkg::IdW'($urandom_range(15))
                                        : reu_pkg::IdW'($urandom);
        pick = $urandom_range(99);
        if (pick < 10) age = reu_pkg::AgeInfinite;
        else if (pick < 75) age = $urandom_range(40);
        else if (pick < 85) age = $urandom_range(3);
        else age = $urandom;
        push_msg(reu_pkg::SelW'($urandom_range(3)), root, cost, sid, age);
        made++;
      end
    end
  endtask

  task automatic wait_drained;
    while (items_pending.size() > 0 || offering || views_due.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count, input bit long_hold);
    idle_pct = idle;
    stall_pct = stall;
    queue_traffic(count);
    if (long_hold) hold_request = 1'b1;
    wait_drained();
  endtask

  // Sender: present the oldest pending item, with random gaps between items
  always @(negedge clk_i) begin
    if (rst_ni && !offering) begin
      if (items_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        msg_ch.action <= items_pending[0].action;
        msg_ch.from_neighbor <= items_pending[0].from_neighbor;
        msg_ch.reported_root <= items_pending[0].reported_root;
        msg_ch.reported_cost <= items_pending[0].reported_cost;
        msg_ch.sender_id <= items_pending[0].sender_id;
        msg_ch.reported_age <= items_pending[0].reported_age;
        msg_ch.valid <= 1'b1;
        offering = 1'b1;
      end else begin
        msg_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && msg_ch.valid && msg_ch.ready) begin
      advance_view(items_pending.pop_front());
      offering = 1'b0;
    end
  end

  // Receiver: random stalls, and one long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    reu_pkg::res_t got;
    reu_pkg::res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.changed = res_ch.changed;
      got.crash_seen = res_ch.crash_seen;
      got.root_id = res_ch.root_id;
      got.path_cost = res_ch.path_cost;
      got.has_parent = res_ch.has_parent;
      got.parent_index = res_ch.parent_index;
      got.advertised_age = res_ch.advertised_age;
      if (views_due.size() == 0) begin
        if (mismatches < 10) $display("unexpected result item: root=%0d cost=%0d",
                                      got.root_id, got.path_cost);
        mismatches++;
      end else begin
        want = views_due.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("mismatch: want chg=%0b crash=%0b root=%0d cost=%0d par=%0b/%0d age=%0d",
                     want.changed, want.crash_seen, want.root_id, want.path_cost,
                     want.has_parent, want.parent_index, want.advertised_age);
            $display("          got  chg=%0b crash=%0b root=%0d cost=%0d par=%0b/%0d age=%0d",
                     got.changed, got.crash_seen, got.root_id, got.path_cost,
                     got.has_parent, got.parent_index, got.advertised_age);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = reu_pkg::CFG_NODE_ID;
    cfg_wdata_i = '0;
    msg_ch.valid = 1'b0;
    msg_ch.action = reu_pkg::ACT_MSG;
    msg_ch.from_neighbor = '0;
    msg_ch.reported_root = '0;
    msg_ch.reported_cost = '0;
    msg_ch.sender_id = '0;
    msg_ch.reported_age = '0;
    res_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(reu_pkg::CFG_NODE_ID, 32'd50);
    write_reg(reu_pkg::CFG_MAX_AGE, 32'd3);
    set_links(16'd1, reu_pkg::CostMax, 16'd10, 16'd2);

    // Adopt on first contact, then saturated cost, worse cost, tie won by smaller id
    push_msg(2'd0, 16'd40, 16'd5, 16'd9, 32'd100);
    push_msg(2'd1, 16'd40, reu_pkg::CostMax, 16'hFFFF, reu_pkg::AgeInfinite);
    push_msg(2'd2, 16'd40, 16'd0, 16'd3, 32'd50);
    push_msg(2'd3, 16'd40, 16'd4, 16'd1, 32'd90);
    push_msg(2'd0, 16'd40, 16'd5, 16'd0, 32'd100);
    // Parent goes silent past max_age
    push_ticks(4);
    push_msg(2'd2, 16'd60, 16'd0, 16'd3, 32'd10);
    push_msg(2'd1, 16'd50, 16'd0, 16'd7, 32'd0);
    // Parent reports an older root age
    push_msg(2'd0, 16'd0, 16'd0, 16'd9, 32'd200);
    push_msg(2'd0, 16'd0, 16'd0, 16'd9, 32'd300);
    // Advertised age floors at zero
    push_msg(2'd3, 16'd0, 16'd0, 16'd1, 32'd1);
    push_ticks(2);
    push_msg(2'd2, 16'd7, 16'd0, 16'd3, 32'd20);
    // Infinite root age advertises max_age
    push_msg(2'd0, 16'd0, 16'd0, 16'd9, reu_pkg::AgeInfinite);
    push_msg(2'd0, 16'd0, 16'd0, 16'd9, 32'd5);
    push_msg(2'd3, 16'hFFFF, reu_pkg::CostMax, 16'hFFFF, 32'd0);
    push_ticks(1);
    push_msg(2'd1, 16'd0, 16'd0, 16'd0, 32'd0);
    wait_drained();

    write_reg(reu_pkg::CFG_MAX_AGE, 32'd5);
    set_links(16'd1, 16'd2, 16'd3, 16'd4);
    run_phase(0, 0, 350, 1'b1);

    write_reg(reu_pkg::CFG_NODE_ID, 32'd0);
    write_reg(reu_pkg::CFG_MAX_AGE, 32'd1);
    set_links(reu_pkg::CostMax, 16'd1, 16'd7, reu_pkg::CostMax);
    run_phase(77, 0, 350, 1'b0);

    write_reg(reu_pkg::CFG_NODE_ID, 32'hFFFF);
    write_reg(reu_pkg::CFG_MAX_AGE, 32'hFFFF_FFFF);
    set_links(16'd3, 16'd3, 16'd3, 16'd3);
    run_phase(0, 77, 350, 1'b0);

    write_reg(reu_pkg::CFG_NODE_ID, 32'd7);
    write_reg(reu_pkg::CFG_MAX_AGE, 32'(reu_pkg::MaxAgeReset));
    set_links(reu_pkg::CostW'($urandom_range(1, 65535)),
              reu_pkg::CostW'($urandom_range(1, 65535)),
              reu_pkg::CostW'($urandom_range(1, 16)),
              reu_pkg::CostW'($urandom_range(1, 16)));
    run_phase(23, 23, 375, 1'b0);

    if (mismatches == 0 && views_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
